/* rtl/core/v3alu_pkg.sv */
// shared types and constants of the three-component vector unit
package v3alu_pkg;

  // mode codes as they arrive on the input
  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_DOT   = 4'd2;
  localparam logic [3:0] MODE_CROSS = 4'd3;
  localparam logic [3:0] MODE_SCALE = 4'd4;
  localparam logic [3:0] MODE_NEG   = 4'd5;
  localparam logic [3:0] MODE_LEN   = 4'd6;
  localparam logic [3:0] MODE_NORM  = 4'd7;
  localparam logic [3:0] MODE_REFL  = 4'd8;
  localparam logic [3:0] MODE_LERP  = 4'd9;

  // decoded operation class
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_DOT, OP_CROSS, OP_SCALE, OP_NEG,
    OP_LEN, OP_NORM, OP_REFL, OP_LERP, OP_NONE
  } op_t;

  // zero-length test: length * 1e6 below one
  localparam int unsigned ZL_RECIP   = 1000000;
  localparam int          ZL_RECIP_W = 20;

  // root / divide sequencer states
  typedef enum logic [1:0] {IT_IDLE, IT_ROOT, IT_DIV, IT_DONE} it_state_t;

  // control from the pipeline to the root / divide unit
  typedef struct packed {
    logic start;
    logic do_div;
    logic ack;
  } it_ctrl_t;

endpackage

/* rtl/core/v3alu_front.sv */
// front end: decodes the mode and prepares the interpolation differences
module v3alu_front #(
  parameter int COMP_WIDTH = 32
) (
  input  logic [3:0]                   mode,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic                         push,
  input  logic                         full,
  output v3alu_pkg::op_t               op,
  output logic signed [COMP_WIDTH:0]   d_x,
  output logic signed [COMP_WIDTH:0]   d_y,
  output logic signed [COMP_WIDTH:0]   d_z,
  output logic                         wr_en
);

  // item taken when the queue has room
  assign wr_en = push & ~full;

  // mode decode
  always_comb begin
    case (mode)
      v3alu_pkg::MODE_ADD:   op = v3alu_pkg::OP_ADD;
      v3alu_pkg::MODE_SUB:   op = v3alu_pkg::OP_SUB;
      v3alu_pkg::MODE_DOT:   op = v3alu_pkg::OP_DOT;
      v3alu_pkg::MODE_CROSS: op = v3alu_pkg::OP_CROSS;
      v3alu_pkg::MODE_SCALE: op = v3alu_pkg::OP_SCALE;
      v3alu_pkg::MODE_NEG:   op = v3alu_pkg::OP_NEG;
      v3alu_pkg::MODE_LEN:   op = v3alu_pkg::OP_LEN;
      v3alu_pkg::MODE_NORM:  op = v3alu_pkg::OP_NORM;
      v3alu_pkg::MODE_REFL:  op = v3alu_pkg::OP_REFL;
      v3alu_pkg::MODE_LERP:  op = v3alu_pkg::OP_LERP;
      default:               op = v3alu_pkg::OP_NONE;
    endcase
  end

  // b - a, one bit wider, for interpolation
  assign d_x = (COMP_WIDTH+1)'(b_x) - (COMP_WIDTH+1)'(a_x);
  assign d_y = (COMP_WIDTH+1)'(b_y) - (COMP_WIDTH+1)'(a_y);
  assign d_z = (COMP_WIDTH+1)'(b_z) - (COMP_WIDTH+1)'(a_z);

endmodule

/* rtl/core/v3alu_fifo.sv */
// two-entry queue between front end and execution pipeline
module v3alu_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full    = count_r[1];
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      if (wr_en && !rd_en) count_r <= count_r + 2'd1;
      else if (!wr_en && rd_en) count_r <= count_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

/* rtl/core/v3alu_iter.sv */
// bit-serial square root, optionally followed by three parallel restoring dividers
module v3alu_iter #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  v3alu_pkg::it_ctrl_t    ctrl,
  input  logic [2*COMP_WIDTH-1:0] sq,
  input  logic [COMP_WIDTH-1:0]  mag [3],
  output logic [COMP_WIDTH-1:0]  root,
  output logic [COMP_WIDTH-1:0]  quo [3],
  output logic                   done
);

  localparam int C  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = C + F;
  localparam int CW = $clog2(NW);

  v3alu_pkg::it_state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r;
  logic           div_r;
  logic [2*C-1:0] sq_r;
  logic [C+1:0]   rem_r;
  logic [C-1:0]   root_r;
  logic [NW-1:0]  num_r  [3];
  logic [C-1:0]   drem_r [3];
  logic [NW-1:0]  quo_r  [3];
  logic           root_en;
  logic           div_en;
  logic [C+3:0]   rem2;
  logic [C+3:0]   trial;
  logic [C:0]     r2 [3];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      v3alu_pkg::IT_IDLE: begin
        if (ctrl.start) state_nxt = v3alu_pkg::IT_ROOT;
      end
      v3alu_pkg::IT_ROOT: begin
        if (cnt_r == '0) state_nxt = div_r ? v3alu_pkg::IT_DIV : v3alu_pkg::IT_DONE;
      end
      v3alu_pkg::IT_DIV: begin
        if (cnt_r == '0) state_nxt = v3alu_pkg::IT_DONE;
      end
      v3alu_pkg::IT_DONE: begin
        if (ctrl.start) state_nxt = v3alu_pkg::IT_ROOT;
        else if (ctrl.ack) state_nxt = v3alu_pkg::IT_IDLE;
      end
      default: state_nxt = v3alu_pkg::IT_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    root_en = 1'b0;
    div_en  = 1'b0;
    done    = 1'b0;
    case (state_r)
      v3alu_pkg::IT_ROOT: root_en = 1'b1;
      v3alu_pkg::IT_DIV:  div_en  = 1'b1;
      v3alu_pkg::IT_DONE: done    = 1'b1;
      default: ;
    endcase
  end

  // one root bit per step
  assign rem2  = {rem_r, sq_r[2*C-1 -: 2]};
  assign trial = (C+4)'({root_r, 2'b01});

  // one quotient bit per step in each lane
  always_comb begin
    for (int i = 0; i < 3; i++) r2[i] = {drem_r[i], num_r[i][NW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= v3alu_pkg::IT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cnt_r  <= CW'(C - 1);
      div_r  <= ctrl.do_div;
      sq_r   <= sq;
      rem_r  <= '0;
      root_r <= '0;
      for (int i = 0; i < 3; i++) num_r[i] <= NW'(mag[i]) << F;
    end else if (root_en) begin
      sq_r <= sq_r << 2;
      if (rem2 >= trial) begin
        rem_r  <= (C+2)'(rem2 - trial);
        root_r <= {root_r[C-2:0], 1'b1};
      end else begin
        rem_r  <= rem2[C+1:0];
        root_r <= {root_r[C-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        cnt_r <= CW'(NW - 1);
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= '0;
          quo_r[i]  <= '0;
        end
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else if (div_en) begin
      cnt_r <= cnt_r - 1'b1;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= num_r[i] << 1;
        if (r2[i] >= {1'b0, root_r}) begin
          drem_r[i] <= C'(r2[i] - {1'b0, root_r});
          quo_r[i]  <= {quo_r[i][NW-2:0], 1'b1};
        end else begin
          drem_r[i] <= r2[i][C-1:0];
          quo_r[i]  <= {quo_r[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r;
  always_comb begin
    for (int i = 0; i < 3; i++) quo[i] = quo_r[i][C-1:0];
  end

endmodule

/* rtl/core/v3alu_back.sv */
// execution pipeline: multiply, combine and saturate, reflect / root stage, result register
module v3alu_back #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  v3alu_pkg::op_t               hd_op,
  input  logic signed [COMP_WIDTH-1:0] hd_a [3],
  input  logic signed [COMP_WIDTH-1:0] hd_b [3],
  input  logic signed [COMP_WIDTH-1:0] hd_s,
  input  logic signed [COMP_WIDTH:0]   hd_d [3],
  input  logic                         hd_empty,
  output logic                         hd_pop,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic signed [COMP_WIDTH-1:0] out_r_scalar,
  output logic                         out_overflow,
  output logic                         out_zero_length,
  output logic                         empty,
  input  logic                         pop
);

  localparam int C  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2*C + 2;
  localparam int WW = 2*C + 4;
  localparam int ZW = C + v3alu_pkg::ZL_RECIP_W + 1;

  // saturate to component range, top bit flags a clip
  function automatic logic [C:0] sat_f(input logic signed [WW-1:0] v);
    logic fits;
    fits = (&v[WW-1:C-1]) | ~(|v[WW-1:C-1]);
    if (fits) return {1'b0, v[C-1:0]};
    else if (v[WW-1]) return {1'b1, 1'b1, {(C-1){1'b0}}};
    else return {1'b1, 1'b0, {(C-1){1'b1}}};
  endfunction

  logic adv;
  logic s3_done;

  // stage 1 registers
  logic                 s1_v_r;
  v3alu_pkg::op_t       s1_op_r;
  logic signed [C-1:0]  s1_a_r [3];
  logic signed [C-1:0]  s1_b_r [3];
  logic signed [PW-1:0] s1_p_r [6];
  // stage 2 registers
  logic                 s2_v_r;
  v3alu_pkg::op_t       s2_op_r;
  logic signed [C-1:0]  s2_a_r [3];
  logic signed [C-1:0]  s2_b_r [3];
  logic signed [C-1:0]  s2_r_r [3];
  logic signed [C-1:0]  s2_rs_r;
  logic                 s2_ov_r;
  logic [2*C-1:0]       s2_sq_r;
  // stage 3 registers
  logic                 s3_v_r;
  v3alu_pkg::op_t       s3_op_r;
  logic signed [C-1:0]  s3_a_r [3];
  logic signed [C-1:0]  s3_r_r [3];
  logic signed [C-1:0]  s3_rs_r;
  logic                 s3_ov_r;
  logic signed [2*C-1:0] s3_p_r [3];
  // result register
  logic                 s4_v_r;
  logic signed [C-1:0]  s4_r_r [3];
  logic signed [C-1:0]  s4_rs_r;
  logic                 s4_ov_r;
  logic                 s4_zl_r;

  // pipeline advances when the result slot frees and the root unit is not busy
  assign adv    = (~s4_v_r | pop) & s3_done;
  assign hd_pop = adv & ~hd_empty;

  // multiplier operand select
  logic signed [C:0] ml [6];
  logic signed [C:0] mr [6];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ml[i] = '0;
      mr[i] = '0;
    end
    case (hd_op)
      v3alu_pkg::OP_DOT, v3alu_pkg::OP_REFL: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = (C+1)'(hd_a[i]);
          mr[i] = (C+1)'(hd_b[i]);
        end
      end
      v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = (C+1)'(hd_a[i]);
          mr[i] = (C+1)'(hd_a[i]);
        end
      end
      v3alu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = (C+1)'(hd_a[i]);
          mr[i] = (C+1)'(hd_s);
        end
      end
      v3alu_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = hd_d[i];
          mr[i] = (C+1)'(hd_s);
        end
      end
      v3alu_pkg::OP_CROSS: begin
        ml[0] = (C+1)'(hd_a[1]); mr[0] = (C+1)'(hd_b[2]);
        ml[1] = (C+1)'(hd_a[2]); mr[1] = (C+1)'(hd_b[0]);
        ml[2] = (C+1)'(hd_a[0]); mr[2] = (C+1)'(hd_b[1]);
        ml[3] = (C+1)'(hd_b[1]); mr[3] = (C+1)'(hd_a[2]);
        ml[4] = (C+1)'(hd_b[2]); mr[4] = (C+1)'(hd_a[0]);
        ml[5] = (C+1)'(hd_b[0]); mr[5] = (C+1)'(hd_a[1]);
      end
      default: ;
    endcase
  end

  // stage 2 combine and saturate
  logic signed [WW-1:0] q;
  logic signed [WW-1:0] w [3];
  logic signed [WW-1:0] ws;
  logic [C:0]           wsat [3];
  logic [C:0]           wssat;
  always_comb begin
    q  = WW'(s1_p_r[0]) + WW'(s1_p_r[1]) + WW'(s1_p_r[2]);
    ws = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = '0;
      case (s1_op_r)
        v3alu_pkg::OP_ADD:   w[i] = WW'(s1_a_r[i]) + WW'(s1_b_r[i]);
        v3alu_pkg::OP_SUB:   w[i] = WW'(s1_a_r[i]) - WW'(s1_b_r[i]);
        v3alu_pkg::OP_NEG:   w[i] = -WW'(s1_a_r[i]);
        v3alu_pkg::OP_SCALE: w[i] = WW'(s1_p_r[i] >>> F);
        v3alu_pkg::OP_CROSS: w[i] = (WW'(s1_p_r[i]) - WW'(s1_p_r[i+3])) >>> F;
        v3alu_pkg::OP_LERP:  w[i] = WW'(s1_a_r[i]) + WW'(s1_p_r[i] >>> F);
        default: ;
      endcase
      wsat[i] = sat_f(w[i]);
    end
    case (s1_op_r)
      v3alu_pkg::OP_DOT, v3alu_pkg::OP_REFL: ws = q >>> F;
      default: ;
    endcase
    wssat = sat_f(ws);
  end

  // reflect second product and root unit hookup
  logic signed [2*C-1:0] rp [3];
  logic [C-1:0]          mag [3];
  logic [C-1:0]          root;
  logic [C-1:0]          quo [3];
  logic                  it_done;
  v3alu_pkg::it_ctrl_t   it_ctrl;
  logic                  s2_iter;
  logic                  s3_iter;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rp[i]  = s2_rs_r * s2_b_r[i];
      mag[i] = s2_a_r[i][C-1] ? C'(-s2_a_r[i]) : s2_a_r[i];
    end
  end

  assign s2_iter = (s2_op_r == v3alu_pkg::OP_LEN) || (s2_op_r == v3alu_pkg::OP_NORM);
  assign s3_iter = (s3_op_r == v3alu_pkg::OP_LEN) || (s3_op_r == v3alu_pkg::OP_NORM);
  assign s3_done = ~(s3_v_r & s3_iter) | it_done;

  assign it_ctrl.start  = adv & s2_v_r & s2_iter;
  assign it_ctrl.do_div = (s2_op_r == v3alu_pkg::OP_NORM);
  assign it_ctrl.ack    = adv;

  v3alu_iter #(
    .COMP_WIDTH (C),
    .FRAC_BITS  (F)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (it_ctrl),
    .sq    (s2_sq_r),
    .mag   (mag),
    .root  (root),
    .quo   (quo),
    .done  (it_done)
  );

  // final stage: reflect subtract, length clip, normalize select
  logic signed [WW-1:0] fw [3];
  logic [C:0]           fsat [3];
  logic [ZW-1:0]        root_z;
  logic [ZW-1:0]        one_z;
  logic                 zl;
  logic signed [C-1:0]  f_r [3];
  logic signed [C-1:0]  f_rs;
  logic                 f_ov;
  logic                 f_zl;
  always_comb begin
    root_z = ZW'(root);
    one_z  = ZW'(1) << F;
    zl     = (root_z < one_z) && ((root_z * ZW'(v3alu_pkg::ZL_RECIP)) < one_z);
    for (int i = 0; i < 3; i++) begin
      fw[i]   = WW'(s3_a_r[i]) - ((WW'(s3_p_r[i]) <<< 1) >>> F);
      fsat[i] = sat_f(fw[i]);
      f_r[i]  = s3_r_r[i];
    end
    f_rs = s3_rs_r;
    f_ov = s3_ov_r;
    f_zl = 1'b0;
    case (s3_op_r)
      v3alu_pkg::OP_REFL: begin
        for (int i = 0; i < 3; i++) f_r[i] = fsat[i][C-1:0];
        f_rs = '0;
        f_ov = s3_ov_r | fsat[0][C] | fsat[1][C] | fsat[2][C];
      end
      v3alu_pkg::OP_LEN: begin
        f_rs = root[C-1] ? {1'b0, {(C-1){1'b1}}} : root;
        f_ov = root[C-1];
      end
      v3alu_pkg::OP_NORM: begin
        f_zl = zl;
        for (int i = 0; i < 3; i++) begin
          if (zl) f_r[i] = s3_a_r[i];
          else f_r[i] = s3_a_r[i][C-1] ? -quo[i] : quo[i];
        end
      end
      default: ;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= ~hd_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end else if (pop) begin
      s4_v_r <= 1'b0;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= hd_empty ? v3alu_pkg::OP_NONE : hd_op;
      for (int i = 0; i < 3; i++) begin
        s1_a_r[i] <= hd_a[i];
        s1_b_r[i] <= hd_b[i];
      end
      for (int i = 0; i < 6; i++) s1_p_r[i] <= ml[i] * mr[i];

      s2_op_r <= s1_op_r;
      for (int i = 0; i < 3; i++) begin
        s2_a_r[i] <= s1_a_r[i];
        s2_b_r[i] <= s1_b_r[i];
        s2_r_r[i] <= wsat[i][C-1:0];
      end
      s2_rs_r <= wssat[C-1:0];
      s2_ov_r <= wsat[0][C] | wsat[1][C] | wsat[2][C] | wssat[C];
      s2_sq_r <= q[2*C-1:0];

      s3_op_r <= s2_op_r;
      for (int i = 0; i < 3; i++) begin
        s3_a_r[i] <= s2_a_r[i];
        s3_r_r[i] <= s2_r_r[i];
        s3_p_r[i] <= rp[i];
      end
      s3_rs_r <= (s2_op_r == v3alu_pkg::OP_REFL) ? '0 : s2_rs_r;
      s3_ov_r <= s2_ov_r;

      for (int i = 0; i < 3; i++) s4_r_r[i] <= f_r[i];
      s4_rs_r <= f_rs;
      s4_ov_r <= f_ov;
      s4_zl_r <= f_zl;
    end
  end

  assign empty           = ~s4_v_r;
  assign out_r_x         = s4_r_r[0];
  assign out_r_y         = s4_r_r[1];
  assign out_r_z         = s4_r_r[2];
  assign out_r_scalar    = s4_rs_r;
  assign out_overflow    = s4_ov_r;
  assign out_zero_length = s4_zl_r;

endmodule

/* rtl/core/vector3_alu.sv */
// top level of the three-component fixed-point vector unit
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-------------------
//  input    | in_mode, in_a_*, in_b_*, in_scalar_in          | push / full
//  result   | out_r_*, out_r_scalar, out_overflow, out_zero_length | empty / pop
//
// add, sub, dot, cross, scale, negate, reflect, interpolate: one item per cycle
// while results are popped and no length or normalize item stalls; each item
// passes queue, multiply, combine, reflect multiply and result register before
// empty goes low. length holds the pipeline while the bit-serial root unit runs;
// normalize holds it for the root, then three parallel one-bit-per-cycle dividers.
// a two-entry queue decouples input from the pipeline; a stalled pop freezes the
// pipeline while the queue still fills. synchronous reset empties both.
module vector3_alu #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [3:0]                   in_mode,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  input  logic signed [COMP_WIDTH-1:0] in_scalar_in,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic signed [COMP_WIDTH-1:0] out_r_scalar,
  output logic                         out_overflow,
  output logic                         out_zero_length
);

  localparam int C  = COMP_WIDTH;
  localparam int EW = 4 + 7*C + 3*(C+1);

  v3alu_pkg::op_t    op;
  logic signed [C:0] d_x, d_y, d_z;
  logic              wr_en;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;
  logic              rd_en;
  logic              q_empty;

  logic signed [C-1:0] hd_a [3];
  logic signed [C-1:0] hd_b [3];
  logic signed [C-1:0] hd_s;
  logic signed [C:0]   hd_d [3];
  v3alu_pkg::op_t      hd_op;

  // decode
  v3alu_front #(
    .COMP_WIDTH (C)
  ) u_front (
    .mode  (in_mode),
    .a_x   (in_a_x),
    .a_y   (in_a_y),
    .a_z   (in_a_z),
    .b_x   (in_b_x),
    .b_y   (in_b_y),
    .b_z   (in_b_z),
    .push  (push),
    .full  (full),
    .op    (op),
    .d_x   (d_x),
    .d_y   (d_y),
    .d_z   (d_z),
    .wr_en (wr_en)
  );

  // queue entry packing
  assign wr_data = {op, in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_scalar_in,
                    d_x, d_y, d_z};

  v3alu_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  // queue entry unpacking
  assign hd_op   = v3alu_pkg::op_t'(rd_data[EW-1 -: 4]);
  assign hd_a[0] = rd_data[EW-5       -: C];
  assign hd_a[1] = rd_data[EW-5-C     -: C];
  assign hd_a[2] = rd_data[EW-5-2*C   -: C];
  assign hd_b[0] = rd_data[EW-5-3*C   -: C];
  assign hd_b[1] = rd_data[EW-5-4*C   -: C];
  assign hd_b[2] = rd_data[EW-5-5*C   -: C];
  assign hd_s    = rd_data[EW-5-6*C   -: C];
  assign hd_d[0] = rd_data[3*(C+1)-1  -: C+1];
  assign hd_d[1] = rd_data[2*(C+1)-1  -: C+1];
  assign hd_d[2] = rd_data[C:0];

  // execution pipeline
  v3alu_back #(
    .COMP_WIDTH (C),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hd_op           (hd_op),
    .hd_a            (hd_a),
    .hd_b            (hd_b),
    .hd_s            (hd_s),
    .hd_d            (hd_d),
    .hd_empty        (q_empty),
    .hd_pop          (rd_en),
    .out_r_x         (out_r_x),
    .out_r_y         (out_r_y),
    .out_r_z         (out_r_z),
    .out_r_scalar    (out_r_scalar),
    .out_overflow    (out_overflow),
    .out_zero_length (out_zero_length),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

/* rtl/core/v3alu_checker.sv */
// port-level checks of the vector unit and their binding
module v3alu_checker #(
  parameter int COMP_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic signed [COMP_WIDTH-1:0] out_r_x,
  input logic signed [COMP_WIDTH-1:0] out_r_y,
  input logic signed [COMP_WIDTH-1:0] out_r_z,
  input logic signed [COMP_WIDTH-1:0] out_r_scalar,
  input logic                         out_overflow,
  input logic                         out_zero_length
);

  // reset leaves both sides empty and ready
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

  // zero-length normalize never has a scalar or a clip
  a_zl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_zero_length) |-> (out_r_scalar == '0) && !out_overflow)
    else $error("zero-length item with scalar or overflow");

  // a scalar result goes with a zero vector
  a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_r_scalar != '0) |-> (out_r_x == '0) && (out_r_y == '0) && (out_r_z == '0))
    else $error("scalar result with nonzero vector");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_r_x) && $stable(out_r_scalar))
    else $error("waiting result changed");

endmodule

bind vector3_alu v3alu_checker #(.COMP_WIDTH(COMP_WIDTH)) u_v3alu_checker (.*);

/* tb/sv/tb_vector3_alu.sv */
// self-checking testbench of the three-component fixed-point vector unit
`timescale 1ns / 100ps

module tb_vector3_alu;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam longint MAX_CYCLES = 1500000;

  // one result item as predicted
  typedef struct {
    logic signed [CW-1:0] rx, ry, rz, rs;
    logic ov, zl;
  } vres_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [3:0] in_mode = '0;
  logic signed [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [CW-1:0] in_scalar_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [CW-1:0] out_r_x, out_r_y, out_r_z, out_r_scalar;
  logic out_overflow, out_zero_length;

  vres_t expected_q[$];
  int errors = 0;
  longint cycle_cnt = 0;
  bit pop_busy_gaps = 1'b1;

  vector3_alu #(.FRAC_BITS(FB), .COMP_WIDTH(CW)) u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_mode(in_mode), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_scalar_in(in_scalar_in),
    .empty(empty), .pop(pop), .out_r_x(out_r_x), .out_r_y(out_r_y),
    .out_r_z(out_r_z), .out_r_scalar(out_r_scalar),
    .out_overflow(out_overflow), .out_zero_length(out_zero_length)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // saturate a wide value to component range
  function automatic logic signed [CW-1:0] sat_comp(input logic signed [127:0] v,
                                                     inout logic ov);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ov = 1'b1;
      return hi[CW-1:0];
    end
    if (v < lo) begin
      ov = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [127:0] r, bitv;
    logic [63:0] root;
    root = '0;
    r = n;
    bitv = 128'd1 << 126;
    for (int i = 0; i < 64; i++) begin
      if (r >= ({64'd0, root} << (128 - 2*i)) + bitv) begin
        r = r - (({64'd0, root} << (128 - 2*i)) + bitv);
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // predict the result of one vector operation
  function automatic vres_t vector_op(input logic [3:0] mode,
      input logic signed [CW-1:0] ax, ay, az, bx, by, bz, s);
    vres_t r;
    logic signed [127:0] a[3], b[3], d, c, p;
    logic signed [127:0] sq;
    logic [63:0] len;
    logic signed [CW-1:0] rv[3], ds;
    logic ov;
    ov = 1'b0;
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    rv[0] = '0; rv[1] = '0; rv[2] = '0;
    r.rs = '0;
    r.zl = 1'b0;
    d = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    case (mode)
      v3alu_pkg::MODE_ADD:
        for (int i = 0; i < 3; i++) rv[i] = sat_comp(a[i] + b[i], ov);
      v3alu_pkg::MODE_SUB:
        for (int i = 0; i < 3; i++) rv[i] = sat_comp(a[i] - b[i], ov);
      v3alu_pkg::MODE_DOT: r.rs = sat_comp(d >>> FB, ov);
      v3alu_pkg::MODE_CROSS: for (int i = 0; i < 3; i++) begin
        c = a[(i+1)%3]*b[(i+2)%3] - b[(i+1)%3]*a[(i+2)%3];
        rv[i] = sat_comp(c >>> FB, ov);
      end
      v3alu_pkg::MODE_SCALE:
        for (int i = 0; i < 3; i++) rv[i] = sat_comp((a[i]*s) >>> FB, ov);
      v3alu_pkg::MODE_NEG: for (int i = 0; i < 3; i++) rv[i] = sat_comp(-a[i], ov);
      v3alu_pkg::MODE_LEN: begin
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        r.rs = sat_comp($signed({64'd0, isqrt128(sq)}), ov);
      end
      v3alu_pkg::MODE_NORM: begin
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        len = isqrt128(sq);
        if (len < (64'd1 << FB) && len * 64'd1000000 < (64'd1 << FB)) begin
          for (int i = 0; i < 3; i++) rv[i] = a[i][CW-1:0];
          r.zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            p = ((a[i] < 0) ? -a[i] : a[i]) <<< FB;
            p = p / $signed({64'd0, len});
            rv[i] = (a[i] < 0) ? -p[CW-1:0] : p[CW-1:0];
          end
        end
      end
      v3alu_pkg::MODE_REFL: begin
        ds = sat_comp(d >>> FB, ov);
        for (int i = 0; i < 3; i++) begin
          p = (2 * ($signed({{96{ds[CW-1]}}, ds}) * b[i])) >>> FB;
          rv[i] = sat_comp(a[i] - p, ov);
        end
      end
      v3alu_pkg::MODE_LERP: for (int i = 0; i < 3; i++) begin
        p = ((b[i] - a[i]) * s) >>> FB;
        rv[i] = sat_comp(a[i] + p, ov);
      end
      default: ;
    endcase
    r.rx = rv[0]; r.ry = rv[1]; r.rz = rv[2];
    r.ov = ov;
    return r;
  endfunction

  // random gap: mostly short, a few long
  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one item and record its prediction
  task automatic send_item(input logic [3:0] mode,
      input logic signed [CW-1:0] ax, ay, az, bx, by, bz, s, input bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_mode <= mode;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    in_scalar_in <= s;
    expected_q.push_back(vector_op(mode, ax, ay, az, bx, by, bz, s));
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic idle_input();
    push <= 1'b0;
  endtask

  // result pop pattern
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        pop <= 1'b0;
      end else begin
        g = pop_busy_gaps ? rand_gap() : 0;
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    vres_t e;
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_r_x !== e.rx) begin
          $error("r_x expected %0d actual %0d", e.rx, out_r_x); errors++;
        end
        if (out_r_y !== e.ry) begin
          $error("r_y expected %0d actual %0d", e.ry, out_r_y); errors++;
        end
        if (out_r_z !== e.rz) begin
          $error("r_z expected %0d actual %0d", e.rz, out_r_z); errors++;
        end
        if (out_r_scalar !== e.rs) begin
          $error("r_scalar expected %0d actual %0d", e.rs, out_r_scalar); errors++;
        end
        if (out_overflow !== e.ov) begin
          $error("overflow expected %0b actual %0b", e.ov, out_overflow); errors++;
        end
        if (out_zero_length !== e.zl) begin
          $error("zero_length expected %0b actual %0b", e.zl, out_zero_length); errors++;
        end
      end
    end
  end

  localparam logic signed [CW-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] VMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  // extremes, every mode, an undefined mode and special cases
  task automatic test_directed();
    for (int m = 0; m < 10; m++)
      send_item(m[3:0], VMAX, VMIN, ONE, VMAX, VMAX, VMIN, VMAX, 1'b0);
    for (int m = 0; m < 10; m++)
      send_item(m[3:0], VMIN, VMIN, VMIN, VMIN, VMAX, -ONE, VMIN, 1'b1);
    // zero vector
    send_item(v3alu_pkg::MODE_NORM, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    // tiny vector
    send_item(v3alu_pkg::MODE_NORM, 32'sd1, -32'sd1, '0, '0, '0, '0, '0, 1'b0);
    // above the zero-length bound
    send_item(v3alu_pkg::MODE_NORM, 32'sd100, '0, '0, '0, '0, '0, '0, 1'b0);
    send_item(v3alu_pkg::MODE_REFL, ONE, ONE, '0, '0, ONE, '0, '0, 1'b0);
    send_item(4'd15, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 1'b0);
    idle_input();
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return VMAX;
      2: return VMIN;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  // random items, mostly defined modes
  task automatic test_random(input int n, input bit gaps);
    logic [3:0] m;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_item(m, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), gaps);
    end
    idle_input();
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1200, 1'b1);
    pop_busy_gaps = 1'b0;
    test_random(600, 1'b0);
    pop_busy_gaps = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/v3alu_pkg.sv
rtl/core/v3alu_front.sv
rtl/core/v3alu_fifo.sv
rtl/core/v3alu_iter.sv
rtl/core/v3alu_back.sv
rtl/core/vector3_alu.sv
rtl/core/v3alu_checker.sv
tb/sv/tb_vector3_alu.sv
